@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/lbmc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbmc_pkg
// Types, register codes and saturating fixed-point helpers for the collision.
// ----------------------------------------------------------------------------
`default_nettype none

package lbmc_pkg;

	localparam int FRAC_BITS_DEF = 24;
	localparam int DATA_W        = 32;
	localparam int DIR_W         = 5;
	localparam int REG_W         = 31;
	localparam int REG_IDX_W     = 3;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	// configuration register codes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_INV_TAU      = 3'd0,
		REG_FORCE_FACTOR = 3'd1,
		REG_GRAVITY      = 3'd2,
		REG_INV_CS_SQ    = 3'd3,
		REG_INV_CS_QUAD  = 3'd4
	} reg_idx_t;

	// weight class of a direction
	typedef enum logic [1:0] {
		WCLS_NONE,
		WCLS_REST,
		WCLS_AXIS,
		WCLS_DIAG
	} wcls_t;

	typedef logic signed [1:0] comp_t;

	typedef struct packed {
		comp_t cx;
		comp_t cy;
		comp_t cz;
		wcls_t wcls;
	} dir_info_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] density;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic signed [DATA_W-1:0] force_z;
		logic signed [DATA_W-1:0] old_population;
		dir_info_t                info;
	} item_t;

	// direction vector and weight class
	function automatic dir_info_t dir_decode(input logic [DIR_W-1:0] d);
		dir_info_t r;
		r = '{cx: 2'sd0, cy: 2'sd0, cz: 2'sd0, wcls: WCLS_NONE};
		case (d)
			5'd1:  r.cx = 2'sd1;
			5'd2:  r.cx = -2'sd1;
			5'd3:  r.cy = 2'sd1;
			5'd4:  r.cy = -2'sd1;
			5'd5:  r.cz = 2'sd1;
			5'd6:  r.cz = -2'sd1;
			5'd7:  begin r.cx = 2'sd1;  r.cy = 2'sd1;  end
			5'd8:  begin r.cx = -2'sd1; r.cy = -2'sd1; end
			5'd9:  begin r.cx = 2'sd1;  r.cy = -2'sd1; end
			5'd10: begin r.cx = -2'sd1; r.cy = 2'sd1;  end
			5'd11: begin r.cx = 2'sd1;  r.cz = 2'sd1;  end
			5'd12: begin r.cx = -2'sd1; r.cz = -2'sd1; end
			5'd13: begin r.cx = 2'sd1;  r.cz = -2'sd1; end
			5'd14: begin r.cx = -2'sd1; r.cz = 2'sd1;  end
			5'd15: begin r.cy = 2'sd1;  r.cz = 2'sd1;  end
			5'd16: begin r.cy = -2'sd1; r.cz = -2'sd1; end
			5'd17: begin r.cy = 2'sd1;  r.cz = -2'sd1; end
			5'd18: begin r.cy = -2'sd1; r.cz = 2'sd1;  end
			default: ;
		endcase
		case (d) inside
			5'd0:           r.wcls = WCLS_REST;
			[5'd1:5'd6]:    r.wcls = WCLS_AXIS;
			[5'd7:5'd18]:   r.wcls = WCLS_DIAG;
			default:        r.wcls = WCLS_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [REG_W-1:0] clamp31(input longint v);
		return (v > 64'sh7FFFFFFF) ? '1 : v[REG_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat64(input longint v);
		logic signed [DATA_W-1:0] r;
		if (v > Q_MAX)
			r = 32'sh7FFFFFFF;
		else if (v < Q_MIN)
			r = 32'sh80000000;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] qadd(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return sat64(longint'(a) + longint'(b));
	endfunction

	function automatic logic signed [DATA_W-1:0] qsub(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return sat64(longint'(a) - longint'(b));
	endfunction

	// exact product, floor shift, saturate
	function automatic logic signed [DATA_W-1:0] qmul(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b,
		input int                       frac
	);
		longint ae;
		longint be;
		ae = longint'(a);
		be = longint'(b);
		return sat64((ae * be) >>> frac);
	endfunction

	function automatic logic signed [DATA_W-1:0] qacc(
		input logic signed [DATA_W-1:0] acc,
		input comp_t                    c,
		input logic signed [DATA_W-1:0] v
	);
		logic signed [DATA_W-1:0] r;
		if (c == 2'sd1)
			r = qadd(acc, v);
		else if (c == -2'sd1)
			r = qsub(acc, v);
		else
			r = acc;
		return r;
	endfunction

	// component times one in fixed point
	function automatic logic signed [DATA_W-1:0] comp_one(input comp_t c, input int frac);
		logic signed [DATA_W-1:0] one;
		logic signed [DATA_W-1:0] r;
		one = DATA_W'(64'sd1 <<< frac);
		if (c == 2'sd1)
			r = one;
		else if (c == -2'sd1)
			r = -one;
		else
			r = '0;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/lbmc_front.sv @@
// ----------------------------------------------------------------------------
// lbmc_front
// Takes start commands, decodes the direction and pushes the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbmc_front (
	input  wire logic                                 start,
	input  wire logic                                 full,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   density,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   vel_x,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   vel_y,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   vel_z,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   force_x,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   force_y,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   force_z,
	input  wire logic        [lbmc_pkg::DIR_W-1:0]    direction,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]   old_population,
	output logic                                      push,
	output lbmc_pkg::item_t                           item
);
	import lbmc_pkg::*;

	// transfer when not full
	assign push = start && !full;

	// pack the item with decoded direction
	always_comb begin
		item.density        = density;
		item.vel_x          = vel_x;
		item.vel_y          = vel_y;
		item.vel_z          = vel_z;
		item.force_x        = force_x;
		item.force_y        = force_y;
		item.force_z        = force_z;
		item.old_population = old_population;
		item.info           = dir_decode(direction);
	end

endmodule

`default_nettype wire

@@ src/lbmc_queue.sv @@
// ----------------------------------------------------------------------------
// lbmc_queue
// Two-entry queue between the command front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module lbmc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lbmc_pkg::item_t push_item,
	input  wire logic            pop,
	output logic                 full,
	output logic                 not_empty,
	output lbmc_pkg::item_t      head
);
	import lbmc_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (!push && do_pop)
				count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

@@ src/lbmc_back.sv @@
// ----------------------------------------------------------------------------
// lbmc_back
// Seven-stage pipeline computing equilibrium and relaxed forced population.
// ----------------------------------------------------------------------------
`default_nettype none

module lbmc_back #(
	parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire lbmc_pkg::item_t                     in_item,
	input  wire logic        [lbmc_pkg::REG_W-1:0]   inv_tau,
	input  wire logic        [lbmc_pkg::REG_W-1:0]   force_factor,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  gravity,
	input  wire logic        [lbmc_pkg::REG_W-1:0]   inv_cs_sq,
	input  wire logic        [lbmc_pkg::REG_W-1:0]   inv_cs_quad,
	output logic                                     done,
	output logic signed      [lbmc_pkg::DATA_W-1:0]  equilibrium,
	output logic signed      [lbmc_pkg::DATA_W-1:0]  new_population
);
	import lbmc_pkg::*;

	localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
	localparam longint WR_L   = (2 * ONE_L + 3) / 6;
	localparam longint WA_L   = (2 * ONE_L + 18) / 36;
	localparam longint WD_L   = (2 * ONE_L + 36) / 72;
	localparam logic signed [DATA_W-1:0] ONE_Q  = ONE_L[DATA_W-1:0];
	localparam logic signed [DATA_W-1:0] W_REST = WR_L[DATA_W-1:0];
	localparam logic signed [DATA_W-1:0] W_AXIS = WA_L[DATA_W-1:0];
	localparam logic signed [DATA_W-1:0] W_DIAG = WD_L[DATA_W-1:0];

	typedef logic signed [DATA_W-1:0] q_t;

	q_t  tau_s;
	q_t  ff_s;
	q_t  csq_s;
	q_t  cqd_s;
	q_t  onemt;
	q_t  w;
	q_t  fz_g;

	logic [7:1] v_q;

	// stage 1
	q_t    uxx_s1, uyy_s1, uzz_s1, cu_s1, rhog_s1, wrho_s1;
	q_t    dx_s1, dy_s1, dz_s1, oldm_s1, ffw_s1, fx_s1, fy_s1, fz_s1;
	comp_t cx_s1, cy_s1, cz_s1;
	// stage 2
	q_t    usq_s2, cusq_s2, cu_s2, fz_s2, cuq_s2, p0_s2, p1_s2, cf_s2;
	q_t    dz_s2, wrho_s2, oldm_s2, ffw_s2;
	// stage 3
	q_t    poly_s3, p2_s3, t2_s3, p0_s3, p1_s3, wrho_s3, oldm_s3, ffw_s3;
	// stage 4
	q_t    t1s_s4, eq_s4, t2_s4, oldm_s4, ffw_s4;
	// stage 5
	q_t    t1_s5, teq_s5, eq_s5, t2_s5, oldm_s5, ffw_s5;
	// stage 6
	q_t    fterm_s6, nw_s6, eq_s6;
	// stage 7
	q_t    nw_s7, eq_s7;

	// register operands as non-negative signed values
	assign tau_s = $signed({1'b0, inv_tau});
	assign ff_s  = $signed({1'b0, force_factor});
	assign csq_s = $signed({1'b0, inv_cs_sq});
	assign cqd_s = $signed({1'b0, inv_cs_quad});
	assign onemt = qsub(ONE_Q, tau_s);
	assign fz_g  = qadd(fz_s1, rhog_s1);

	// weight from class
	always_comb begin
		case (in_item.info.wcls)
			WCLS_REST: w = W_REST;
			WCLS_AXIS: w = W_AXIS;
			WCLS_DIAG: w = W_DIAG;
			default:   w = '0;
		endcase
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else
			v_q <= {v_q[6:1], in_valid};
	end

	// arithmetic pipeline
	always_ff @(posedge clk) begin
		// squares, velocity projection, first products
		uxx_s1  <= qmul(in_item.vel_x, in_item.vel_x, FRAC_BITS);
		uyy_s1  <= qmul(in_item.vel_y, in_item.vel_y, FRAC_BITS);
		uzz_s1  <= qmul(in_item.vel_z, in_item.vel_z, FRAC_BITS);
		cu_s1   <= qacc(qacc(qacc('0, in_item.info.cx, in_item.vel_x),
			in_item.info.cy, in_item.vel_y), in_item.info.cz, in_item.vel_z);
		rhog_s1 <= qmul(in_item.density, gravity, FRAC_BITS);
		wrho_s1 <= qmul(w, in_item.density, FRAC_BITS);
		dx_s1   <= qsub(comp_one(in_item.info.cx, FRAC_BITS), in_item.vel_x);
		dy_s1   <= qsub(comp_one(in_item.info.cy, FRAC_BITS), in_item.vel_y);
		dz_s1   <= qsub(comp_one(in_item.info.cz, FRAC_BITS), in_item.vel_z);
		oldm_s1 <= qmul(in_item.old_population, onemt, FRAC_BITS);
		ffw_s1  <= qmul(ff_s, w, FRAC_BITS);
		fx_s1   <= in_item.force_x;
		fy_s1   <= in_item.force_y;
		fz_s1   <= in_item.force_z;
		cx_s1   <= in_item.info.cx;
		cy_s1   <= in_item.info.cy;
		cz_s1   <= in_item.info.cz;

		// speed squared, gravity on z, force projection
		usq_s2  <= qadd(qadd(uxx_s1, uyy_s1), uzz_s1);
		cusq_s2 <= qmul(cu_s1, cu_s1, FRAC_BITS);
		cu_s2   <= cu_s1;
		fz_s2   <= fz_g;
		cuq_s2  <= qmul(cu_s1, cqd_s, FRAC_BITS);
		p0_s2   <= qmul(dx_s1, fx_s1, FRAC_BITS);
		p1_s2   <= qmul(dy_s1, fy_s1, FRAC_BITS);
		cf_s2   <= qacc(qacc(qacc('0, cx_s1, fx_s1), cy_s1, fy_s1), cz_s1, fz_g);
		dz_s2   <= dz_s1;
		wrho_s2 <= wrho_s1;
		oldm_s2 <= oldm_s1;
		ffw_s2  <= ffw_s1;

		// equilibrium polynomial
		poly_s3 <= qsub(qadd(qadd(ONE_Q, qadd(qadd(cu_s2, cu_s2), cu_s2)),
			sat64(4 * longint'(cusq_s2) + (longint'(cusq_s2) >>> 1))),
			sat64(longint'(usq_s2) + (longint'(usq_s2) >>> 1)));
		p2_s3   <= qmul(dz_s2, fz_s2, FRAC_BITS);
		t2_s3   <= qmul(cuq_s2, cf_s2, FRAC_BITS);
		p0_s3   <= p0_s2;
		p1_s3   <= p1_s2;
		wrho_s3 <= wrho_s2;
		oldm_s3 <= oldm_s2;
		ffw_s3  <= ffw_s2;

		// equilibrium, first forcing sum
		t1s_s4  <= qadd(qadd(p0_s3, p1_s3), p2_s3);
		eq_s4   <= qmul(wrho_s3, poly_s3, FRAC_BITS);
		t2_s4   <= t2_s3;
		oldm_s4 <= oldm_s3;
		ffw_s4  <= ffw_s3;

		// scale by inverse sound speed squared and inverse tau
		t1_s5   <= qmul(t1s_s4, csq_s, FRAC_BITS);
		teq_s5  <= qmul(tau_s, eq_s4, FRAC_BITS);
		eq_s5   <= eq_s4;
		t2_s5   <= t2_s4;
		oldm_s5 <= oldm_s4;
		ffw_s5  <= ffw_s4;

		// forcing term, relaxed part
		fterm_s6 <= qmul(ffw_s5, qadd(t1_s5, t2_s5), FRAC_BITS);
		nw_s6    <= qadd(oldm_s5, teq_s5);
		eq_s6    <= eq_s5;

		// final sum
		nw_s7 <= qadd(nw_s6, fterm_s6);
		eq_s7 <= eq_s6;
	end

	assign done           = v_q[7];
	assign equilibrium    = eq_s7;
	assign new_population = nw_s7;

endmodule

`default_nettype wire

@@ src/lbm_d3q19_forced_collision.sv @@
// ----------------------------------------------------------------------------
// lbm_d3q19_forced_collision
// D3Q19 BGK collision with body forcing, one population per command.
// ----------------------------------------------------------------------------
// Usage:
// - configuration: write inv_tau, force_factor, gravity, inv_cs_sq and
//   inv_cs_quad through wr_en / wr_index / wr_data while the block is idle
// - command: drive the node fields, direction and old population with start;
//   the transfer happens at a rising edge with start high and busy low
// - result: done pulses for one cycle with equilibrium and new_population,
//   after the queue and pipeline; there is no back-pressure on results
// - throughput: one command per cycle; the seven-stage multiply pipeline
//   never stalls, so the two-entry queue never fills and busy stays low
// - reset: arst_n clears the queue and pipeline valids and loads the
//   registers with 1.0, 0.5, 0, 3.0 and 9.0 in fixed point
// - direction codes 19 to 31 give zero weight and zero velocity vector
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_d3q19_forced_collision #(
	parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic        [lbmc_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic        [lbmc_pkg::DATA_W-1:0]  wr_data,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  density,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  vel_x,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  vel_y,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  vel_z,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  force_x,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  force_y,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  force_z,
	input  wire logic        [lbmc_pkg::DIR_W-1:0]   direction,
	input  wire logic signed [lbmc_pkg::DATA_W-1:0]  old_population,
	output logic                                     done,
	output logic signed      [lbmc_pkg::DATA_W-1:0]  equilibrium,
	output logic signed      [lbmc_pkg::DATA_W-1:0]  new_population
);
	import lbmc_pkg::*;

	localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
	localparam logic [REG_W-1:0] RST_INV_TAU = clamp31(ONE_L);
	localparam logic [REG_W-1:0] RST_FF      = clamp31(ONE_L / 2);
	localparam logic [REG_W-1:0] RST_CS_SQ   = clamp31(3 * ONE_L);
	localparam logic [REG_W-1:0] RST_CS_QUAD = clamp31(9 * ONE_L);

	logic [REG_W-1:0]         inv_tau_q;
	logic [REG_W-1:0]         force_factor_q;
	logic signed [DATA_W-1:0] gravity_q;
	logic [REG_W-1:0]         inv_cs_sq_q;
	logic [REG_W-1:0]         inv_cs_quad_q;

	logic  push;
	item_t push_item;
	logic  full;
	logic  not_empty;
	item_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tau_q      <= RST_INV_TAU;
			force_factor_q <= RST_FF;
			gravity_q      <= '0;
			inv_cs_sq_q    <= RST_CS_SQ;
			inv_cs_quad_q  <= RST_CS_QUAD;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_INV_TAU:      inv_tau_q      <= wr_data[REG_W-1:0];
				REG_FORCE_FACTOR: force_factor_q <= wr_data[REG_W-1:0];
				REG_GRAVITY:      gravity_q      <= $signed(wr_data);
				REG_INV_CS_SQ:    inv_cs_sq_q    <= wr_data[REG_W-1:0];
				REG_INV_CS_QUAD:  inv_cs_quad_q  <= wr_data[REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = full;

	// command front
	lbmc_front u_front (
		.start          (start),
		.full           (full),
		.density        (density),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.vel_z          (vel_z),
		.force_x        (force_x),
		.force_y        (force_y),
		.force_z        (force_z),
		.direction      (direction),
		.old_population (old_population),
		.push           (push),
		.item           (push_item)
	);

	// decoupling queue
	lbmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (1'b1),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	// arithmetic back
	lbmc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (not_empty),
		.in_item        (head),
		.inv_tau        (inv_tau_q),
		.force_factor   (force_factor_q),
		.gravity        (gravity_q),
		.inv_cs_sq      (inv_cs_sq_q),
		.inv_cs_quad    (inv_cs_quad_q),
		.done           (done),
		.equilibrium    (equilibrium),
		.new_population (new_population)
	);

endmodule

`default_nettype wire

@@ src/lbmc_checker.sv @@
// ----------------------------------------------------------------------------
// lbmc_checker
// Port-level checks of busy and command-to-result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lbmc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	localparam int LAT = 8;

	logic [3:0] warm_q;
	logic       xfer;
	logic       warm;

	assign xfer = start && !busy;
	assign warm = (warm_q == 4'(LAT));

	// cycles since reset, saturating at the latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			warm_q <= '0;
		else if (!warm)
			warm_q <= warm_q + 4'd1;
	end

	`ASSERT_IMPL(a_never_busy, 1'b1, !busy)
	`ASSERT_IMPL(a_xfer_gives_done, xfer, ##8 done)
	`ASSERT_IMPL(a_done_has_xfer, warm && done, $past(xfer, 8))
	`ASSERT_NEXT(a_no_done_after_reset, !warm && warm_q == 4'd0, !done)

endmodule

bind lbm_d3q19_forced_collision lbmc_checker u_lbmc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

@@ tb/sv/tb_lbm_d3q19_forced_collision.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lbm_d3q19_forced_collision
// Drives collision commands with random node data through several register
// settings and idle patterns; a scoreboard predicts each population update in
// saturating fixed point and checks every done pulse in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lbm_d3q19_forced_collision;
	import lbmc_pkg::*;

	localparam int FB = 24;
	localparam longint ONE_Q = longint'(1) << FB;
	localparam longint W_REST = (2 * ONE_Q + 3) / 6;
	localparam longint W_AXIS = (2 * ONE_Q + 18) / 36;
	localparam longint W_DIAG = (2 * ONE_Q + 36) / 72;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		longint eq;
		longint pop;
	} collision_t;

	// collision predictor and queue of expected populations
	class collision_board;
		longint inv_tau, force_factor, gravity, inv_cs_sq, inv_cs_quad;
		collision_t pending[$];
		int errors;

		function new();
			inv_tau = ONE_Q;
			force_factor = ONE_Q / 2;
			gravity = 0;
			inv_cs_sq = 3 * ONE_Q;
			inv_cs_quad = 9 * ONE_Q;
			errors = 0;
		endfunction

		function longint clip(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint mulq(longint a, longint b);
			return clip((a * b) >>> FB);
		endfunction

		function longint signed_step(longint acc, int c, longint v);
			if (c > 0) return clip(acc + v);
			if (c < 0) return clip(acc - v);
			return acc;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_INV_TAU:      inv_tau = longint'(v[30:0]);
				REG_FORCE_FACTOR: force_factor = longint'(v[30:0]);
				REG_GRAVITY:      gravity = longint'(signed'(v));
				REG_INV_CS_SQ:    inv_cs_sq = longint'(v[30:0]);
				REG_INV_CS_QUAD:  inv_cs_quad = longint'(v[30:0]);
				default: ;
			endcase
		endfunction

		// predict one population update from a command
		function void note_command(longint rho, longint u[3], longint fin[3], int dir,
				longint old);
			int cv[3];
			longint f[3];
			longint w, usq, cu, cu2, poly, eq, t1, t2, cf, br, ft, nw;
			collision_t r;
			cv = '{0, 0, 0};
			w = 0;
			f = fin;
			case (dir)
				1: cv[0] = 1;   2: cv[0] = -1;  3: cv[1] = 1;   4: cv[1] = -1;
				5: cv[2] = 1;   6: cv[2] = -1;
				7: cv = '{1, 1, 0};    8: cv = '{-1, -1, 0};
				9: cv = '{1, -1, 0};   10: cv = '{-1, 1, 0};
				11: cv = '{1, 0, 1};   12: cv = '{-1, 0, -1};
				13: cv = '{1, 0, -1};  14: cv = '{-1, 0, 1};
				15: cv = '{0, 1, 1};   16: cv = '{0, -1, -1};
				17: cv = '{0, 1, -1};  18: cv = '{0, -1, 1};
				default: ;
			endcase
			if (dir == 0) w = W_REST;
			else if (dir <= 6) w = W_AXIS;
			else if (dir <= 18) w = W_DIAG;
			usq = clip(clip(mulq(u[0], u[0]) + mulq(u[1], u[1])) + mulq(u[2], u[2]));
			cu = 0;
			for (int i = 0; i < 3; i++) cu = signed_step(cu, cv[i], u[i]);
			cu2 = mulq(cu, cu);
			poly = clip(ONE_Q + clip(clip(cu + cu) + cu));
			poly = clip(poly + clip(4 * cu2 + (cu2 >>> 1)));
			poly = clip(poly - clip(usq + (usq >>> 1)));
			eq = mulq(mulq(w, rho), poly);
			f[2] = clip(f[2] + mulq(rho, gravity));
			t1 = 0;
			cf = 0;
			for (int i = 0; i < 3; i++) begin
				t1 = clip(t1 + mulq(clip(longint'(cv[i]) * ONE_Q - u[i]), f[i]));
				cf = signed_step(cf, cv[i], f[i]);
			end
			t1 = mulq(t1, inv_cs_sq);
			t2 = mulq(mulq(cu, inv_cs_quad), cf);
			br = clip(t1 + t2);
			ft = mulq(mulq(force_factor, w), br);
			nw = mulq(old, clip(ONE_Q - inv_tau));
			nw = clip(nw + mulq(inv_tau, eq));
			nw = clip(nw + ft);
			r.eq = eq;
			r.pop = nw;
			pending.push_back(r);
		endfunction

		function void check_result(longint eq, longint pop);
			collision_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result eq=%0d pop=%0d", eq, pop);
				return;
			end
			e = pending.pop_front();
			if (e.eq != eq || e.pop != pop) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: eq exp %0d got %0d, pop exp %0d got %0d",
						e.eq, eq, e.pop, pop);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [DATA_W-1:0] wr_data = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [DATA_W-1:0] density = '0, vel_x = '0, vel_y = '0, vel_z = '0;
	logic signed [DATA_W-1:0] force_x = '0, force_y = '0, force_z = '0;
	logic [DIR_W-1:0] direction = '0;
	logic signed [DATA_W-1:0] old_population = '0;
	logic done;
	logic signed [DATA_W-1:0] equilibrium, new_population;

	collision_board board = new();
	int idle_pct = 0;

	lbm_d3q19_forced_collision #(.FRAC_BITS(FB)) DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// check every done pulse
	always @(posedge clk)
		if (arst_n && done)
			board.check_result(longint'(equilibrium), longint'(new_population));

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		board.set_reg(idx, v);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// stop sending and wait for the pipeline to drain before touching registers
	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_q(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2 * (1 << FB))) - (1 << FB));
			2: return 32'($signed($urandom_range(0, 1 << (FB - 2))) - (1 << (FB - 3)));
			default: return $urandom_range(0, 3) == 0 ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	// one command transfer, with optional idle gap before it
	task automatic send(logic [31:0] v[8], int dir);
		longint u[3], f[3];
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		density <= v[0]; vel_x <= v[1]; vel_y <= v[2]; vel_z <= v[3];
		force_x <= v[4]; force_y <= v[5]; force_z <= v[6]; old_population <= v[7];
		direction <= dir[4:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'(signed'(v[1 + i]));
			f[i] = longint'(signed'(v[4 + i]));
		end
		board.note_command(longint'(signed'(v[0])), u, f, dir, longint'(signed'(v[7])));
		@(negedge clk);
	endtask

	task automatic random_batch(int n);
		logic [31:0] v[8];
		int mode;
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(0, 9) < 7 ? $urandom_range(1, 2) : $urandom_range(0, 3);
			foreach (v[i]) v[i] = $urandom_range(0, 7) == 0 ? rand_q(0) : rand_q(mode);
			send(v, $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 18));
		end
	endtask

	initial begin
		#2_000_000;
		$display("FAIL lbm_d3q19_forced_collision");
		$finish;
	end

	initial begin
		logic [31:0] v[8];
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: every direction plus unused codes 19 and 31, then field extremes
		for (int d = 0; d < 21; d++) begin
			foreach (v[i]) v[i] = rand_q(1);
			send(v, d == 20 ? 31 : d);
		end
		foreach (v[i]) v[i] = 32'h7FFFFFFF;
		send(v, 7);
		foreach (v[i]) v[i] = 32'h80000000;
		send(v, 8);
		foreach (v[i]) v[i] = 32'h0;
		send(v, 0);

		// phases over register settings and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				1: begin
					write_reg(REG_INV_TAU, 32'h7FFFFFFF);
					write_reg(REG_FORCE_FACTOR, 32'h0);
					write_reg(REG_GRAVITY, 32'h80000000);
					write_reg(REG_INV_CS_SQ, 32'h0);
					write_reg(REG_INV_CS_QUAD, 32'h7FFFFFFF);
				end
				2: begin
					write_reg(REG_INV_TAU, 32'h0);
					write_reg(REG_FORCE_FACTOR, 32'h7FFFFFFF);
					write_reg(REG_GRAVITY, 32'h7FFFFFFF);
					write_reg(REG_INV_CS_SQ, 32'h7FFFFFFF);
					write_reg(REG_INV_CS_QUAD, 32'h0);
				end
				default: begin
					write_reg(REG_INV_TAU, $urandom_range(0, 2 << FB));
					write_reg(REG_FORCE_FACTOR, $urandom_range(0, 1 << FB));
					write_reg(REG_GRAVITY, rand_q(2));
					write_reg(REG_INV_CS_SQ, $urandom());
					write_reg(REG_INV_CS_QUAD, $urandom_range(0, 16 << FB));
				end
			endcase
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 53 : 36);
			random_batch(250);
		end

		drain();
		if (board.errors == 0)
			$display("PASS lbm_d3q19_forced_collision");
		else
			$display("FAIL lbm_d3q19_forced_collision");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/lbmc_pkg.sv
src/lbmc_front.sv
src/lbmc_queue.sv
src/lbmc_back.sv
src/lbm_d3q19_forced_collision.sv
src/lbmc_checker.sv
tb/sv/tb_lbm_d3q19_forced_collision.sv
